// File: rtl/hkct_pkg.sv
// hkct_pkg: shared constants, types and state codes for the hashed key count table
// no dependencies
`default_nettype none
package hkct_pkg;
   localparam int BUCKETS = 2048;
   localparam int NODES = 1024;
   localparam int KEY_BITS = 20;
   localparam int COUNT_BITS = 16;
   localparam int BKT_BITS = $clog2(BUCKETS);
   localparam int NODE_BITS = $clog2(NODES);
   localparam int FREE_BITS = NODE_BITS + 1;
   localparam int WEIGHT_BITS = KEY_BITS + COUNT_BITS;
   localparam int TOTAL_BITS = 48;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_LOOKUP = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_HEAD, ST_NODE, ST_CHECK, ST_WRITE, ST_MULT, ST_ACC, ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load_item;
      logic head_read;
      logic node_read;
      logic follow;
      logic upd_write;
      logic new_write;
      logic mult;
      logic acc;
      logic out_load;
      logic out_drop;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic is_lookup;
      logic cur_valid;
      logic hit;
      logic store_full;
      logic out_busy;
   } sts_type;
endpackage
`default_nettype wire

// File: rtl/hkct_if.sv
// hkct_if: valid/ready channel carrying one word of a payload type
// depends on nothing
`default_nettype none
interface hkct_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/hkct_ctrl.sv
// hkct_ctrl: sequencer for clear, chain walk, insert update or lookup weighting, and result delivery
// depends on hkct_pkg
`default_nettype none
module hkct_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  hkct_pkg::sts_type     sts,
   output hkct_pkg::cmd_type     cmd
);
   hkct_pkg::state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) state_ff <= hkct_pkg::ST_CLEAR;
      else state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hkct_pkg::ST_CLEAR: if (sts.clear_done) state_in = hkct_pkg::ST_IDLE;
         hkct_pkg::ST_IDLE: if (req_valid) state_in = hkct_pkg::ST_HEAD;
         hkct_pkg::ST_HEAD: state_in = hkct_pkg::ST_CHECK;
         hkct_pkg::ST_NODE: state_in = hkct_pkg::ST_CHECK;
         hkct_pkg::ST_CHECK: begin
            priority if (sts.cur_valid && !sts.hit) state_in = hkct_pkg::ST_NODE;
            else if (sts.is_lookup) state_in = hkct_pkg::ST_MULT;
            else state_in = hkct_pkg::ST_WRITE;
         end
         hkct_pkg::ST_WRITE: state_in = hkct_pkg::ST_OUT;
         hkct_pkg::ST_MULT: state_in = hkct_pkg::ST_ACC;
         hkct_pkg::ST_ACC: state_in = hkct_pkg::ST_OUT;
         hkct_pkg::ST_OUT: if (!sts.out_busy) state_in = hkct_pkg::ST_IDLE;
         default: state_in = hkct_pkg::ST_CLEAR;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         hkct_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
         hkct_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load_item = req_valid;
         end
         hkct_pkg::ST_HEAD: cmd.head_read = 1'b1;
         hkct_pkg::ST_NODE: cmd.node_read = 1'b1;
         hkct_pkg::ST_CHECK: cmd.follow = sts.cur_valid && !sts.hit;
         hkct_pkg::ST_WRITE: begin
            cmd.upd_write = sts.hit;
            cmd.new_write = !sts.hit && !sts.store_full;
            cmd.out_drop = !sts.hit && sts.store_full;
         end
         hkct_pkg::ST_MULT: cmd.mult = 1'b1;
         hkct_pkg::ST_ACC: cmd.acc = 1'b1;
         hkct_pkg::ST_OUT: cmd.out_load = !sts.out_busy;
         default: ;
      endcase
   end

   a_one_read: assert property (@(posedge clock) disable iff (reset)
      !(cmd.head_read && cmd.node_read)) else $error("two reads");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == hkct_pkg::ST_IDLE) else $error("ready out of idle");
   a_accept_walk: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == hkct_pkg::ST_HEAD) else $error("no walk");
endmodule
`default_nettype wire

// File: rtl/hkct_dpath.sv
// hkct_dpath: bucket and node memories, walk pointer, multiply, total, output register
// depends on hkct_pkg
`default_nettype none
module hkct_dpath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  hkct_pkg::cmd_type                      cmd,
   output hkct_pkg::sts_type                      sts,
   input  wire logic                              in_kind,
   input  wire logic [hkct_pkg::KEY_BITS-1:0]     in_key,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output logic [hkct_pkg::COUNT_BITS-1:0]        out_count,
   output logic [hkct_pkg::WEIGHT_BITS-1:0]       out_weighted,
   output logic [hkct_pkg::TOTAL_BITS-1:0]        out_total,
   output logic                                   out_dropped
);
   localparam int HEAD_W = hkct_pkg::NODE_BITS + 1;
   localparam int NODE_W = hkct_pkg::KEY_BITS + hkct_pkg::COUNT_BITS + 1 + hkct_pkg::NODE_BITS;

   // memories: bucket heads {valid, index}, nodes {key, count, next valid, next}
   logic [HEAD_W-1:0] head_mem [hkct_pkg::BUCKETS];
   logic [NODE_W-1:0] node_mem [hkct_pkg::NODES];

   logic                                 kind_ff;
   logic [hkct_pkg::KEY_BITS-1:0]        key_ff;
   logic [hkct_pkg::BKT_BITS-1:0]        clr_ff;
   logic                                 clr_done_ff;
   logic [HEAD_W-1:0]                    head_rd_ff;
   logic [NODE_W-1:0]                    node_rd_ff;
   logic                                 from_head_ff;
   logic [hkct_pkg::NODE_BITS-1:0]       cur_ff;
   logic [hkct_pkg::FREE_BITS-1:0]       free_ff;
   logic [hkct_pkg::COUNT_BITS-1:0]      cnt_ff;
   logic [hkct_pkg::WEIGHT_BITS-1:0]     wt_ff;
   logic [hkct_pkg::TOTAL_BITS-1:0]      total_ff;
   logic                                 drop_ff;
   logic                                 out_valid_ff;
   logic [hkct_pkg::COUNT_BITS-1:0]      o_cnt_ff;
   logic [hkct_pkg::WEIGHT_BITS-1:0]     o_wt_ff;
   logic [hkct_pkg::TOTAL_BITS-1:0]      o_total_ff;
   logic                                 o_drop_ff;

   logic [hkct_pkg::BKT_BITS-1:0]        bucket;
   logic                                 cur_valid;
   logic [hkct_pkg::NODE_BITS-1:0]       cur_idx;
   logic [hkct_pkg::KEY_BITS-1:0]        n_key;
   logic [hkct_pkg::COUNT_BITS-1:0]      n_cnt;
   logic                                 n_nv;
   logic [hkct_pkg::NODE_BITS-1:0]       n_next;
   logic                                 hit;
   logic [hkct_pkg::COUNT_BITS-1:0]      cnt_inc;
   logic [hkct_pkg::TOTAL_BITS:0]        sum;

   assign bucket = key_ff[hkct_pkg::BKT_BITS-1:0];
   assign {n_key, n_cnt, n_nv, n_next} = node_rd_ff;
   // current chain pointer comes from the head read or the node's next link
   assign cur_valid = from_head_ff ? head_rd_ff[HEAD_W-1] : n_nv;
   assign cur_idx = from_head_ff ? head_rd_ff[HEAD_W-2:0] : n_next;
   assign hit = !from_head_ff && (n_key == key_ff);
   assign cnt_inc = (n_cnt == hkct_pkg::COUNT_MAX) ? n_cnt : n_cnt + 1'b1;
   assign sum = {1'b0, total_ff} + {{(hkct_pkg::TOTAL_BITS-hkct_pkg::WEIGHT_BITS+1){1'b0}}, wt_ff};

   // in check state the head or node data just read holds either a hit or the next link
   assign sts.clear_done = clr_done_ff;
   assign sts.is_lookup = kind_ff == hkct_pkg::KIND_LOOKUP;
   assign sts.cur_valid = cur_valid && !hit;
   assign sts.hit = hit;
   assign sts.store_full = free_ff[hkct_pkg::FREE_BITS-1];
   assign sts.out_busy = out_valid_ff && !out_ready;

   // bucket head memory: clear sweep, head read, new head write
   always_ff @(posedge clock) begin
      if (cmd.clear_step) head_mem[clr_ff] <= '0;
      else if (cmd.new_write)
         head_mem[bucket] <= {1'b1, free_ff[hkct_pkg::NODE_BITS-1:0]};
      head_rd_ff <= head_mem[bucket];
   end

   // node memory: one write port, one read port
   always_ff @(posedge clock) begin
      if (cmd.upd_write) node_mem[cur_ff] <= {n_key, cnt_inc, n_nv, n_next};
      else if (cmd.new_write)
         node_mem[free_ff[hkct_pkg::NODE_BITS-1:0]] <=
            {key_ff, {{(hkct_pkg::COUNT_BITS-1){1'b0}}, 1'b1}, head_rd_ff};
      if (cmd.node_read) node_rd_ff <= node_mem[cur_ff];
   end

   // clear sweep counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         clr_done_ff <= 1'b0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
         if (clr_ff == hkct_pkg::BKT_BITS'(hkct_pkg::BUCKETS - 2)) clr_done_ff <= 1'b1;
      end
   end

   // item, walk pointer and result working registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff <= in_kind;
         key_ff <= in_key;
      end
      if (cmd.head_read) from_head_ff <= 1'b1;
      if (cmd.node_read) from_head_ff <= 1'b0;
      if (cmd.follow) cur_ff <= cur_idx;
      if (cmd.head_read) begin
         cnt_ff <= '0;
         drop_ff <= 1'b0;
      end
      if (cmd.upd_write) cnt_ff <= cnt_inc;
      if (cmd.new_write) cnt_ff <= {{(hkct_pkg::COUNT_BITS-1){1'b0}}, 1'b1};
      if (cmd.out_drop) drop_ff <= 1'b1;
      if (cmd.mult) begin
         cnt_ff <= hit ? n_cnt : '0;
         wt_ff <= hit ? key_ff * n_cnt : '0;
      end
      if (cmd.head_read) wt_ff <= '0;
   end

   // allocation pointer and saturating total
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff <= '0;
         total_ff <= '0;
      end else begin
         if (cmd.new_write) free_ff <= free_ff + 1'b1;
         if (cmd.acc) total_ff <= sum[hkct_pkg::TOTAL_BITS] ? hkct_pkg::TOTAL_MAX
                                                     : sum[hkct_pkg::TOTAL_BITS-1:0];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.out_load) out_valid_ff <= 1'b1;
      else if (out_ready) out_valid_ff <= 1'b0;
      if (cmd.out_load) begin
         o_cnt_ff <= cnt_ff;
         o_wt_ff <= wt_ff;
         o_total_ff <= total_ff;
         o_drop_ff <= drop_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_count = o_cnt_ff;
   assign out_weighted = o_wt_ff;
   assign out_total = o_total_ff;
   assign out_dropped = o_drop_ff;

   a_no_double_write: assert property (@(posedge clock) disable iff (reset)
      !(cmd.upd_write && cmd.new_write)) else $error("two node writes");
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= hkct_pkg::FREE_BITS'(hkct_pkg::NODES)) else $error("free overrun");
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      cmd.out_drop |-> sts.store_full) else $error("drop while not full");
endmodule
`default_nettype wire

// File: rtl/hashed_key_count_table_core.sv
// hashed_key_count_table_core: top level of the chained hash key counter
// depends on hkct_pkg, hkct_if, hkct_ctrl, hkct_dpath
//
// channel  dir  payload
// req      in   kind, key
// rsp      out  count, weighted, total, dropped
//
// an insert passes the head, check, write and out states, a lookup head, check, mult, acc and out
// each node visited on the chain adds a node read state and a check state
// after reset a clearing pass over all 2048 buckets empties the bucket table; no word taken then
// the result sits in an output register; the next word waits only if it is still held
// reset is synchronous and active high
`default_nettype none
module hashed_key_count_table_core (
   input  wire logic clock,
   input  wire logic reset,
   hkct_if.sink      req,
   hkct_if.source    rsp
);
   hkct_pkg::cmd_type cmd;
   hkct_pkg::sts_type sts;

   hkct_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
      .sts(sts), .cmd(cmd)
   );

   hkct_dpath u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_kind(req.data.kind), .in_key(req.data.key),
      .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_count(rsp.data.count), .out_weighted(rsp.data.weighted),
      .out_total(rsp.data.total), .out_dropped(rsp.data.dropped)
   );
endmodule
`default_nettype wire

// File: sim/hashed_key_count_table_core_test.sv
// hashed_key_count_table_core_test: self-checking bench for the chained hash key counter
// depends on hkct_pkg, hkct_if and the hashed_key_count_table_core rtl
`default_nettype none
module hashed_key_count_table_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                          kind;
      logic [hkct_pkg::KEY_BITS-1:0] key;
   } req_word_type;

   typedef struct packed {
      logic [hkct_pkg::COUNT_BITS-1:0]  count;
      logic [hkct_pkg::WEIGHT_BITS-1:0] weighted;
      logic [hkct_pkg::TOTAL_BITS-1:0]  total;
      logic                             dropped;
   } rsp_word_type;

   // mirror of the key table with a queue of predicted answers
   class key_count_table;
      bit                            head_used [hkct_pkg::BUCKETS];
      bit [hkct_pkg::NODE_BITS-1:0]  head_node [hkct_pkg::BUCKETS];
      bit [hkct_pkg::KEY_BITS-1:0]   node_key [hkct_pkg::NODES];
      bit [hkct_pkg::COUNT_BITS-1:0] node_count [hkct_pkg::NODES];
      bit                            link_used [hkct_pkg::NODES];
      bit [hkct_pkg::NODE_BITS-1:0]  link_node [hkct_pkg::NODES];
      int                            nodes_taken;
      bit [hkct_pkg::TOTAL_BITS-1:0] sum;
      rsp_word_type                  answers [$];
      int                            errors;
      int                            checked;
      int                            drops_seen;

      function void clear();
         foreach (head_used[b]) head_used[b] = 1'b0;
         nodes_taken = 0;
         sum = '0;
         errors = 0;
         checked = 0;
         drops_seen = 0;
      endfunction

      // walk the chain of the key's bucket, -1 when absent
      function int locate(bit [hkct_pkg::KEY_BITS-1:0] key);
         bit [hkct_pkg::BKT_BITS-1:0]  b;
         bit                           more;
         bit [hkct_pkg::NODE_BITS-1:0] n;
         b = key[hkct_pkg::BKT_BITS-1:0];
         more = head_used[b];
         n = head_node[b];
         for (int steps = 0; steps < hkct_pkg::NODES && more; steps++) begin
            if (node_key[n] == key) return int'(n);
            more = link_used[n];
            n = link_node[n];
         end
         return -1;
      endfunction

      function void note(req_word_type w);
         rsp_word_type                 r;
         int                           at;
         bit [hkct_pkg::BKT_BITS-1:0]  b;
         bit [hkct_pkg::TOTAL_BITS:0]  wide;
         r = '0;
         at = locate(w.key);
         b = w.key[hkct_pkg::BKT_BITS-1:0];
         if (w.kind == hkct_pkg::KIND_INSERT) begin
            if (at >= 0) begin
               if (node_count[at] != hkct_pkg::COUNT_MAX) node_count[at]++;
               r.count = node_count[at];
            end else if (nodes_taken < hkct_pkg::NODES) begin
               node_key[nodes_taken] = w.key;
               node_count[nodes_taken] = hkct_pkg::COUNT_BITS'(1);
               link_used[nodes_taken] = head_used[b];
               link_node[nodes_taken] = head_node[b];
               head_used[b] = 1'b1;
               head_node[b] = hkct_pkg::NODE_BITS'(nodes_taken);
               nodes_taken++;
               r.count = hkct_pkg::COUNT_BITS'(1);
            end else begin
               r.dropped = 1'b1;
            end
         end else begin
            if (at >= 0) r.count = node_count[at];
            r.weighted = hkct_pkg::WEIGHT_BITS'(w.key) * hkct_pkg::WEIGHT_BITS'(r.count);
            wide = {1'b0, sum} + (hkct_pkg::TOTAL_BITS + 1)'(r.weighted);
            sum = wide[hkct_pkg::TOTAL_BITS] ? hkct_pkg::TOTAL_MAX
                                             : wide[hkct_pkg::TOTAL_BITS-1:0];
         end
         r.total = sum;
         answers.push_back(r);
      endfunction

      function void check(rsp_word_type got);
         rsp_word_type want;
         if (answers.size() == 0) begin
            $display("%0t: unexpected result word %h", $realtime, got);
            errors++;
            return;
         end
         want = answers.pop_front();
         checked++;
         if (got.dropped) drops_seen++;
         if (got.count !== want.count) begin
            $display("%0t: count expected %0d actual %0d", $realtime, want.count, got.count);
            errors++;
         end
         if (got.weighted !== want.weighted) begin
            $display("%0t: weighted expected %0d actual %0d", $realtime, want.weighted,
                     got.weighted);
            errors++;
         end
         if (got.total !== want.total) begin
            $display("%0t: total expected %0d actual %0d", $realtime, want.total, got.total);
            errors++;
         end
         if (got.dropped !== want.dropped) begin
            $display("%0t: dropped expected %0b actual %0b", $realtime, want.dropped,
                     got.dropped);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   int   stall_left = 0;
   key_count_table table_mirror = new();
   bit [hkct_pkg::KEY_BITS-1:0] seen_keys [$];

   hkct_if #(.payload_type(req_word_type)) req_ch ();
   hkct_if #(.payload_type(rsp_word_type)) rsp_ch ();

   hashed_key_count_table_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   // result side: ready with random stall bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // compare each accepted result word
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) table_mirror.check(rsp_ch.data);
   end

   // send one request word, with an occasional gap before it
   task automatic send_word(logic kind, logic [hkct_pkg::KEY_BITS-1:0] key, bit gaps);
      req_word_type w;
      w.kind = kind;
      w.key = key;
      if (gaps && !quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      table_mirror.note(w);
      if (kind == hkct_pkg::KIND_INSERT) seen_keys.push_back(key);
   endtask

   // key that is known, shares a bucket with a known one, or is fresh
   function automatic logic [hkct_pkg::KEY_BITS-1:0] pick_key();
      int sel;
      sel = $urandom_range(0, 9);
      if (seen_keys.size() == 0 || sel < 3) return hkct_pkg::KEY_BITS'($urandom);
      if (sel < 5)
         return {hkct_pkg::KEY_BITS'($urandom) >> hkct_pkg::BKT_BITS << hkct_pkg::BKT_BITS}
                | seen_keys[$urandom_range(0, seen_keys.size() - 1)][hkct_pkg::BKT_BITS-1:0];
      return seen_keys[$urandom_range(0, seen_keys.size() - 1)];
   endfunction

   initial begin
      logic [hkct_pkg::KEY_BITS-1:0] fresh;
      table_mirror.clear();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty lookups, bucket collisions, extreme keys
      send_word(hkct_pkg::KIND_LOOKUP, '0, 1);
      send_word(hkct_pkg::KIND_INSERT, '0, 1);
      send_word(hkct_pkg::KIND_INSERT, '0, 1);
      send_word(hkct_pkg::KIND_LOOKUP, '0, 1);
      send_word(hkct_pkg::KIND_INSERT, '1, 1);
      send_word(hkct_pkg::KIND_INSERT, hkct_pkg::KEY_BITS'(hkct_pkg::BUCKETS - 1), 1);
      send_word(hkct_pkg::KIND_INSERT, hkct_pkg::KEY_BITS'(hkct_pkg::BUCKETS), 1);
      send_word(hkct_pkg::KIND_INSERT, hkct_pkg::KEY_BITS'(hkct_pkg::BUCKETS), 1);
      send_word(hkct_pkg::KIND_LOOKUP, hkct_pkg::KEY_BITS'(hkct_pkg::BUCKETS - 1), 1);
      send_word(hkct_pkg::KIND_LOOKUP, hkct_pkg::KEY_BITS'(hkct_pkg::BUCKETS), 1);
      send_word(hkct_pkg::KIND_LOOKUP, '1, 1);
      send_word(hkct_pkg::KIND_LOOKUP, hkct_pkg::KEY_BITS'(2 * hkct_pkg::BUCKETS), 1);
      send_word(hkct_pkg::KIND_LOOKUP, hkct_pkg::KEY_BITS'(hkct_pkg::BUCKETS + 1), 1);

      // random mix over known, colliding and fresh keys
      for (int i = 0; i < 250; i++)
         send_word(logic'($urandom_range(0, 9) < 6 ? hkct_pkg::KIND_INSERT
                                                   : hkct_pkg::KIND_LOOKUP), pick_key(), 1);

      // fill the node store and go past it
      quiet = 1'b1;
      while (table_mirror.nodes_taken < hkct_pkg::NODES)
         send_word(hkct_pkg::KIND_INSERT, hkct_pkg::KEY_BITS'($urandom), 0);
      for (int i = 0; i < 40; i++) begin
         fresh = hkct_pkg::KEY_BITS'($urandom);
         send_word(i % 2 ? hkct_pkg::KIND_LOOKUP : hkct_pkg::KIND_INSERT,
                   i % 4 == 3 ? pick_key() : fresh, 0);
      end
      req_ch.valid <= 1'b0;

      while (table_mirror.answers.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      $display("checked %0d result words, %0d nodes allocated, %0d inserts dropped",
               table_mirror.checked, table_mirror.nodes_taken, table_mirror.drops_seen);
      $display("covered repeated keys, bucket collisions, absent lookups and a full store");
      if (table_mirror.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire

// File: sim.f
rtl/hkct_pkg.sv
rtl/hkct_if.sv
rtl/hkct_ctrl.sv
rtl/hkct_dpath.sv
rtl/hashed_key_count_table_core.sv
sim/hashed_key_count_table_core_test.sv
